>>> hw/rtl/rbfnc_pkg.sv
// package for the record bitmap block: sizes, request codes and shared structs
// no dependencies; imported by every module of the block
package rbfnc_pkg;

    localparam int MAX_RECORDS  = 4096;
    localparam int WORD_W       = 64;
    localparam int NUM_WORDS    = MAX_RECORDS / WORD_W;
    localparam int WORD_AW      = $clog2(NUM_WORDS);
    localparam int BIT_AW       = $clog2(WORD_W);
    localparam int IDX_W        = WORD_AW + BIT_AW;
    localparam int VAL_W        = 13;
    localparam int ACT_W        = 3;
    localparam int CNT_W        = BIT_AW + 1;

    localparam logic [VAL_W-1:0] DEFAULT_SIZE = VAL_W'(256);
    localparam logic [VAL_W-1:0] MAX_SIZE     = VAL_W'(MAX_RECORDS);

    localparam logic [ACT_W-1:0] ACT_GET   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NEXT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_COUNT = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [VAL_W-1:0] record;
    } t_req;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             error;
    } t_rsp;

    typedef struct packed {
        logic               we;
        logic [WORD_AW-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
        logic [WORD_AW-1:0] rd_addr;
    } t_mem_ctl;

    typedef struct packed {
        logic              lo_en;
        logic [BIT_AW-1:0] lo_off;
        logic              hi_en;
        logic [BIT_AW-1:0] hi_off;
    } t_scan_ctl;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              found;
        logic [BIT_AW-1:0] pos;
    } t_scan_res;

endpackage

>>> hw/rtl/rbfnc_store.sv
// bit store: 64 words of 64 bits, one write and one registered read per cycle
// per-word valid bits give the all-zero reset; uses rbfnc_pkg
module rbfnc_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rbfnc_pkg::t_mem_ctl i_mem,
    output logic [rbfnc_pkg::WORD_W-1:0] o_rdata
);
    import rbfnc_pkg::*;

    logic [WORD_W-1:0]    r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_valid;
    logic [WORD_W-1:0]    r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_mem.we) begin
            r_valid[i_mem.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.wr_addr] <= i_mem.wr_data;
        end
        r_rdata <= r_valid[i_mem.rd_addr] ? r_mem[i_mem.rd_addr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/rbfnc_unit.sv
// shared word unit: masks one stored word, counts its set bits and finds the lowest one
// uses rbfnc_pkg
module rbfnc_unit (
    input  logic [rbfnc_pkg::WORD_W-1:0] i_word,
    input  rbfnc_pkg::t_scan_ctl         i_ctl,
    output rbfnc_pkg::t_scan_res         o_res
);
    import rbfnc_pkg::*;

    logic [WORD_W-1:0] mask_lo;
    logic [WORD_W-1:0] mask_hi;
    logic [WORD_W-1:0] w;
    logic [CNT_W-1:0]  cnt;
    logic [BIT_AW-1:0] pos;

    always_comb begin
        mask_lo = i_ctl.lo_en ? ({WORD_W{1'b1}} << i_ctl.lo_off) : {WORD_W{1'b1}};
        mask_hi = i_ctl.hi_en ? ({WORD_W{1'b1}} >> (BIT_AW'(WORD_W - 1) - i_ctl.hi_off))
                              : {WORD_W{1'b1}};
        w   = i_word & mask_lo & mask_hi;
        cnt = CNT_W'($countones(w));
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                pos = BIT_AW'(i);
            end
        end
        o_res.count = cnt;
        o_res.found = |w;
        o_res.pos   = pos;
    end

endmodule

>>> hw/rtl/rbfnc_ctrl.sv
// sequencer: takes requests, walks the store one word a cycle, holds the result register
// drives the bit store and the shared word unit; uses rbfnc_pkg
module rbfnc_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  rbfnc_pkg::t_req              i_in_req,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output rbfnc_pkg::t_rsp              o_out_rsp,
    input  logic                         i_cfg_we,
    input  logic [rbfnc_pkg::VAL_W-1:0]  i_cfg_data,
    input  logic [rbfnc_pkg::WORD_W-1:0] i_rdata,
    input  rbfnc_pkg::t_scan_res         i_scan,
    output rbfnc_pkg::t_mem_ctl          o_mem,
    output rbfnc_pkg::t_scan_ctl         o_scan
);
    import rbfnc_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PRIME, S_SCAN, S_BIT, S_RESP} t_state;

    t_state             r_state, n_state;
    logic [ACT_W-1:0]   r_op, n_op;
    logic [WORD_AW-1:0] r_cur, n_cur;
    logic [BIT_AW-1:0]  r_off, n_off;
    logic               r_first, n_first;
    logic [VAL_W-1:0]   r_acc, n_acc;
    t_rsp               r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out, n_out;
    logic [VAL_W-1:0]   r_map_size, n_map_size;

    logic [VAL_W-1:0]   size;
    logic [VAL_W-1:0]   size_m1;
    logic [WORD_AW-1:0] last_word;
    logic               out_free;
    logic               accept;
    logic               bad_rec;
    logic [IDX_W-1:0]   rec_idx;
    logic [VAL_W-1:0]   acc_sum;
    logic [WORD_W-1:0]  wdata;

    always_comb begin
        if (r_map_size == '0) begin
            size = DEFAULT_SIZE;
        end else if (r_map_size > MAX_SIZE) begin
            size = MAX_SIZE;
        end else begin
            size = r_map_size;
        end
        size_m1   = size - VAL_W'(1);
        last_word = size_m1[IDX_W-1:BIT_AW];
        out_free  = !r_out_valid || !i_out_stall;
        accept    = i_in_valid && (r_state == S_IDLE) && out_free;
        bad_rec   = (i_in_req.record == '0) || (i_in_req.record > size);
        rec_idx   = IDX_W'(i_in_req.record - VAL_W'(1));
        acc_sum   = r_acc + VAL_W'(i_scan.count);
        wdata     = i_rdata;
        wdata[r_off] = (r_op == ACT_SET);
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_cur       = r_cur;
        n_off       = r_off;
        n_first     = r_first;
        n_acc       = r_acc;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_map_size  = i_cfg_we ? i_cfg_data : r_map_size;

        o_mem.we      = 1'b0;
        o_mem.wr_addr = r_cur;
        o_mem.wr_data = wdata;
        o_mem.rd_addr = (r_state == S_SCAN) ? r_cur + WORD_AW'(1) : r_cur;

        o_scan.lo_en  = r_first;
        o_scan.lo_off = r_off;
        o_scan.hi_en  = (r_cur == last_word);
        o_scan.hi_off = size_m1[BIT_AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op    = i_in_req.action;
                    n_acc   = '0;
                    n_first = 1'b0;
                    case (i_in_req.action)
                        ACT_GET, ACT_SET, ACT_CLEAR: begin
                            if (bad_rec) begin
                                n_out_valid = 1'b1;
                                n_out       = '{value: '0, error: 1'b1};
                            end else begin
                                n_cur   = rec_idx[IDX_W-1:BIT_AW];
                                n_off   = rec_idx[BIT_AW-1:0];
                                n_state = S_PRIME;
                            end
                        end
                        ACT_NEXT: begin
                            if (i_in_req.record >= size) begin
                                n_out_valid = 1'b1;
                                n_out       = '{value: '0, error: 1'b0};
                            end else begin
                                n_cur   = i_in_req.record[IDX_W-1:BIT_AW];
                                n_off   = i_in_req.record[BIT_AW-1:0];
                                n_first = 1'b1;
                                n_state = S_PRIME;
                            end
                        end
                        ACT_COUNT: begin
                            n_cur   = '0;
                            n_off   = '0;
                            n_state = S_PRIME;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out       = '{value: '0, error: 1'b0};
                        end
                    endcase
                end
            end
            S_PRIME: begin
                n_state = ((r_op == ACT_NEXT) || (r_op == ACT_COUNT)) ? S_SCAN : S_BIT;
            end
            S_BIT: begin
                n_res = '{value: '0, error: 1'b0};
                if (r_op == ACT_GET) begin
                    n_res.value = VAL_W'(i_rdata[r_off]);
                end else begin
                    o_mem.we = 1'b1;
                end
                n_state = S_RESP;
            end
            S_SCAN: begin
                n_first = 1'b0;
                if (r_op == ACT_NEXT) begin
                    if (i_scan.found) begin
                        n_res   = '{value: VAL_W'({r_cur, i_scan.pos}) + VAL_W'(1),
                                    error: 1'b0};
                        n_state = S_RESP;
                    end else if (r_cur == last_word) begin
                        n_res   = '{value: '0, error: 1'b0};
                        n_state = S_RESP;
                    end else begin
                        n_cur = r_cur + WORD_AW'(1);
                    end
                end else begin
                    n_acc = acc_sum;
                    if (r_cur == last_word) begin
                        n_res   = '{value: acc_sum, error: 1'b0};
                        n_state = S_RESP;
                    end else begin
                        n_cur = r_cur + WORD_AW'(1);
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_first     <= 1'b0;
            r_map_size  <= DEFAULT_SIZE;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_first     <= n_first;
            r_map_size  <= n_map_size;
        end
        r_op  <= n_op;
        r_cur <= n_cur;
        r_off <= n_off;
        r_acc <= n_acc;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

>>> hw/rtl/record_bitmap_find_next_count_top.sv
// Record bitmap of up to 4096 records (record r is bit r-1), cleared at reset, with get,
// set, clear, find-next-set and count requests; one result per request. The store is read
// one 64-bit word per cycle and a single word unit masks, counts and searches that word, so
// a request holds the block for its whole duration: get, set and clear pass through prime,
// bit access and response; a bad record, a find-next past the end or an unknown action is
// answered directly from idle; find-next walks up to 64 words and count walks every word
// up to the map size. A new request is taken only when the output register is empty or its
// result leaves in the same cycle.
// top level: rbfnc_store, rbfnc_unit, rbfnc_ctrl; uses rbfnc_pkg
module record_bitmap_find_next_count_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  rbfnc_pkg::t_req             i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output rbfnc_pkg::t_rsp             o_out_rsp,
    input  logic                        i_cfg_we,
    input  logic [rbfnc_pkg::VAL_W-1:0] i_cfg_data
);
    import rbfnc_pkg::*;

    t_mem_ctl          mem;
    t_scan_ctl         scan_ctl;
    t_scan_res         scan_res;
    logic [WORD_W-1:0] rdata;

    rbfnc_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mem   (mem),
        .o_rdata (rdata)
    );

    rbfnc_unit u_unit (
        .i_word (rdata),
        .i_ctl  (scan_ctl),
        .o_res  (scan_res)
    );

    rbfnc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_rdata     (rdata),
        .i_scan      (scan_res),
        .o_mem       (mem),
        .o_scan      (scan_ctl)
    );

endmodule

>>> hw/rtl/rbfnc_checker.sv
// port-level checks for the record bitmap top level, attached by bind
// uses rbfnc_pkg
module rbfnc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input rbfnc_pkg::t_req             i_in_req,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input rbfnc_pkg::t_rsp             o_out_rsp
);
    import rbfnc_pkg::*;

    logic in_acc;
    logic bit_op;

    assign in_acc = i_in_valid && !o_in_stall;
    assign bit_op = (i_in_req.action == ACT_GET) || (i_in_req.action == ACT_SET) ||
                    (i_in_req.action == ACT_CLEAR);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_rsp))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.error |-> o_out_rsp.value == '0)
        else $error("error result with nonzero value");

    a_rec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && bit_op && (i_in_req.record == '0) |=> o_out_valid && o_out_rsp.error)
        else $error("record zero not flagged");

    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("request taken while result blocked");

    a_busy_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_req.action == ACT_COUNT) |=> o_in_stall)
        else $error("count request did not hold the block");

endmodule

bind record_bitmap_find_next_count_top rbfnc_checker u_chk (.*);

>>> tb/record_bitmap_find_next_count_top_tb.sv
// testbench for record_bitmap_find_next_count_top: get, set, clear, find-next and count requests
// with random gaps and stalls, checked against a bitmap predictor held in a scoreboard class
// depends on rbfnc_pkg and record_bitmap_find_next_count_top
`timescale 1ns / 100ps

module record_bitmap_find_next_count_top_tb;
    import rbfnc_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;
    localparam logic [VAL_W-1:0] TOP_RECORD  = 13'h1FFF;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int NUM_PHASES      = 9;
    localparam int PRESSURE_PHASE  = 3;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 600000;

    class bitmap_scoreboard;
        bit [MAX_RECORDS-1:0] map_bits;
        logic [VAL_W-1:0] map_size;
        t_rsp replies_due[$];
        int bad_replies;
        int last_found;

        function new();
            map_bits = '0;
            map_size = DEFAULT_SIZE;
            bad_replies = 0;
            last_found = 0;
        endfunction

        function int effective_size();
            if (map_size == 0) begin
                return int'(DEFAULT_SIZE);
            end
            if (map_size > MAX_SIZE) begin
                return MAX_RECORDS;
            end
            return int'(map_size);
        endfunction

        function void write_size(logic [VAL_W-1:0] v);
            map_size = v;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void note_request(t_req req);
            int span;
            int rec;
            t_rsp want;
            span = effective_size();
            rec = int'(req.record);
            want = '0;
            case (req.action)
                ACT_GET, ACT_SET, ACT_CLEAR: begin
                    if (rec == 0 || rec > span) begin
                        want.error = 1'b1;
                    end else if (req.action == ACT_GET) begin
                        want.value = VAL_W'(map_bits[rec-1]);
                    end else if (req.action == ACT_SET) begin
                        map_bits[rec-1] = 1'b1;
                    end else begin
                        map_bits[rec-1] = 1'b0;
                    end
                end
                ACT_NEXT: begin
                    for (int i = rec; i < span; i++) begin
                        if (map_bits[i]) begin
                            want.value = VAL_W'(i + 1);
                            break;
                        end
                    end
                    last_found = int'(want.value);
                end
                ACT_COUNT: begin
                    for (int i = 0; i < span; i++) begin
                        want.value = want.value + VAL_W'(map_bits[i]);
                    end
                end
                default: ;
            endcase
            replies_due.push_back(want);
        endfunction

        function void check_reply(t_rsp got);
            t_rsp want;
            if (replies_due.size() == 0) begin
                if (bad_replies < 10) begin
                    $display("unexpected reply: value %0d error %0b", got.value, got.error);
                end
                bad_replies++;
                return;
            end
            want = replies_due.pop_front();
            if (got.value !== want.value || got.error !== want.error) begin
                if (bad_replies < 10) begin
                    $display("reply mismatch: expected value %0d error %0b, got value %0d error %0b",
                             want.value, want.error, got.value, got.error);
                end
                bad_replies++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_req             i_in_req;
    logic             o_out_valid;
    logic             i_out_stall;
    t_rsp             o_out_rsp;
    logic             i_cfg_we;
    logic [VAL_W-1:0] i_cfg_data;

    bitmap_scoreboard sb = new();
    bit no_gaps = 1'b0;
    bit hold_off_req = 1'b0;
    int cycle_count = 0;

    record_bitmap_find_next_count_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_req make_req(logic [ACT_W-1:0] act, logic [VAL_W-1:0] rec);
        t_req req;
        req.action = act;
        req.record = rec;
        return req;
    endfunction

    function automatic t_req random_request();
        t_req req;
        int span;
        int pick;
        span = sb.effective_size();
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            req.action = ACT_SET;
        end else if (pick < 47) begin
            req.action = ACT_CLEAR;
        end else if (pick < 65) begin
            req.action = ACT_GET;
        end else if (pick < 87) begin
            req.action = ACT_NEXT;
        end else if (pick < 96) begin
            req.action = ACT_COUNT;
        end else begin
            req.action = ACT_W'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
        end
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            req.record = VAL_W'($urandom_range(1, span));
        end else if (pick < 80) begin
            req.record = '0;
        end else if (pick < 85) begin
            req.record = VAL_W'(span);
        end else if (pick < 90) begin
            req.record = VAL_W'(span + 1);
        end else begin
            req.record = VAL_W'($urandom_range(0, TOP_RECORD));
        end
        // walk the set records one after another
        if (req.action == ACT_NEXT && $urandom_range(0, 2) == 0) begin
            req.record = VAL_W'(sb.last_found);
        end
        return req;
    endfunction

    task automatic send_request(input t_req req);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_map_size(input logic [VAL_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_size(v);
    endtask

    // reply side: random stalls, one long hold-off on request
    initial begin
        int n;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                n = HOLD_OFF_CYCLES;
            end else begin
                n = no_gaps ? 0 : $urandom_range(0, 3);
            end
            @(negedge i_clk);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_reply(o_out_rsp);
        end
    end

    initial begin
        t_req directed[$];
        logic [VAL_W-1:0] sizes [NUM_PHASES];
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        sizes = '{13'd1, 13'd4096, 13'd0, TOP_RECORD, 13'd4097, 13'd100, 13'd64, 13'd65, 13'd0};
        sizes[NUM_PHASES-1] = VAL_W'($urandom_range(1, TOP_RECORD));
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed = '{
            make_req(ACT_COUNT, 13'd0),   make_req(ACT_NEXT, 13'd0),
            make_req(ACT_GET, 13'd1),     make_req(ACT_SET, 13'd1),
            make_req(ACT_SET, 13'd256),   make_req(ACT_SET, 13'd128),
            make_req(ACT_SET, 13'd64),    make_req(ACT_SET, 13'd65),
            make_req(ACT_GET, 13'd1),     make_req(ACT_GET, 13'd256),
            make_req(ACT_SET, 13'd0),     make_req(ACT_SET, 13'd257),
            make_req(ACT_GET, TOP_RECORD), make_req(ACT_CLEAR, 13'd0),
            make_req(ACT_NEXT, 13'd0),    make_req(ACT_NEXT, 13'd1),
            make_req(ACT_NEXT, 13'd65),   make_req(ACT_NEXT, 13'd255),
            make_req(ACT_NEXT, 13'd256),  make_req(ACT_NEXT, TOP_RECORD),
            make_req(ACT_COUNT, 13'd0),   make_req(ACT_CLEAR, 13'd256),
            make_req(ACT_COUNT, TOP_RECORD), make_req(ACT_SPARE_A, TOP_RECORD),
            make_req(ACT_SPARE_B, 13'd1), make_req(ACT_SPARE_C, 13'd0)
        };
        foreach (directed[k]) send_request(directed[k]);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            write_map_size(sizes[phase]);
            if (phase == PRESSURE_PHASE) begin
                hold_off_req = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) begin
                    no_gaps = (phase == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
                end
                send_request(random_request());
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.bad_replies == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
